// ===== rtl/core/tfb_pkg.sv =====
// Shared types, codes and helper functions for the text frame buffer cursor engine.
// Used by tfb_cursor, tfb_seq and the top module in rtl/core; depends on nothing else.
package tfb_pkg;

  typedef enum logic [3:0] {
    KIND_WRITE    = 4'd0,
    KIND_SET      = 4'd1,
    KIND_STEP     = 4'd2,
    KIND_CLR_CELL = 4'd3,
    KIND_CLR_ROW  = 4'd4,
    KIND_CLR_COL  = 4'd5,
    KIND_CLR_ALL  = 4'd6,
    KIND_SHIFT    = 4'd7,
    KIND_ROTATE   = 4'd8,
    KIND_READ     = 4'd9
  } kind_e;

  localparam logic [2:0] DIR_LEFT  = 3'd0;
  localparam logic [2:0] DIR_RIGHT = 3'd1;
  localparam logic [2:0] DIR_UP    = 3'd2;
  localparam logic [2:0] DIR_DOWN  = 3'd3;

  localparam logic [7:0] SPACE_CHAR = 8'h20;

  // Command word as it arrives on the input stream, last field (kind) in the low bits.
  typedef struct packed {
    logic [7:0] band_width;
    logic [7:0] band_start;
    logic [2:0] direction;
    logic [7:0] column;
    logic [7:0] row;
    logic [7:0] char_code;
    logic [3:0] kind;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_WRITE,
    ST_MREAD,
    ST_MDRAIN,
    ST_MLAST,
    ST_RDREQ,
    ST_RESP
  } state_e;

  function automatic logic [7:0] clamp_idx(input logic [7:0] v, input logic [7:0] lim);
    return (v >= lim) ? (lim - 8'd1) : v;
  endfunction

  // Band width cut at the edge; a start at or past the edge gives zero.
  function automatic logic [7:0] band_clamp(input logic [7:0] start, input logic [7:0] width,
                                            input logic [7:0] lim);
    logic [8:0] room;
    room = {1'b0, lim} - {1'b0, start};
    if (start >= lim) begin
      return 8'd0;
    end
    return ({1'b0, width} > room) ? room[7:0] : width;
  endfunction

  function automatic logic in_band(input logic [7:0] cur, input logic [7:0] start,
                                   input logic [7:0] w);
    return (cur >= start) && ({1'b0, cur} < ({1'b0, start} + {1'b0, w}));
  endfunction

endpackage

// ===== rtl/core/tfb_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Standalone; no package needed.
module tfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/tfb_cursor.sv =====
// Cursor register and its update rules for every command kind.
// Depends on tfb_pkg for the command word, codes and clamp helpers.
module tfb_cursor #(
  parameter int ROWS    = 2,
  parameter int COLUMNS = 16,
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int CW = $clog2(COLUMNS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          upd_i,
  input  tfb_pkg::cmd_t cmd_i,
  output logic [RW-1:0] row_o,
  output logic [CW-1:0] col_o
);
  import tfb_pkg::*;

  localparam logic [7:0]    LIM_R = 8'(ROWS);
  localparam logic [7:0]    LIM_C = 8'(COLUMNS);
  localparam logic [RW-1:0] ROW_L = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_L = CW'(COLUMNS - 1);

  logic [RW-1:0] row_q, row_d, row_inc, row_dec;
  logic [CW-1:0] col_q, col_d, col_inc, col_dec;
  logic [7:0]    w_rows, w_cols;

  always_comb begin
    row_inc = (row_q == ROW_L) ? '0 : row_q + RW'(1);
    row_dec = (row_q == '0) ? ROW_L : row_q - RW'(1);
    col_inc = (col_q == COL_L) ? '0 : col_q + CW'(1);
    col_dec = (col_q == '0) ? COL_L : col_q - CW'(1);
    w_rows  = band_clamp(cmd_i.band_start, cmd_i.band_width, LIM_R);
    w_cols  = band_clamp(cmd_i.band_start, cmd_i.band_width, LIM_C);
    row_d   = row_q;
    col_d   = col_q;
    case (kind_e'(cmd_i.kind))
      KIND_WRITE: begin
        col_d = col_inc;
        if (col_q == COL_L) begin
          row_d = row_inc;
        end
      end
      KIND_SET, KIND_CLR_CELL, KIND_CLR_ROW, KIND_CLR_COL: begin
        row_d = RW'(clamp_idx(cmd_i.row, LIM_R));
        col_d = CW'(clamp_idx(cmd_i.column, LIM_C));
      end
      KIND_STEP: begin
        case (cmd_i.direction)
          DIR_LEFT: begin
            col_d = col_dec;
            if (col_q == '0) begin
              row_d = row_dec;
            end
          end
          DIR_RIGHT: begin
            col_d = col_inc;
            if (col_q == COL_L) begin
              row_d = row_inc;
            end
          end
          DIR_UP:   row_d = row_dec;
          DIR_DOWN: row_d = row_inc;
          default: ;
        endcase
      end
      KIND_CLR_ALL: begin
        row_d = '0;
        col_d = '0;
      end
      KIND_SHIFT: begin
        case (cmd_i.direction)
          DIR_LEFT: begin
            row_d = RW'(clamp_idx(cmd_i.band_start, LIM_R));
            col_d = COL_L;
          end
          DIR_RIGHT: begin
            row_d = RW'(clamp_idx(cmd_i.band_start, LIM_R));
            col_d = '0;
          end
          DIR_UP: begin
            row_d = ROW_L;
            col_d = CW'(clamp_idx(cmd_i.band_start, LIM_C));
          end
          DIR_DOWN: begin
            row_d = '0;
            col_d = CW'(clamp_idx(cmd_i.band_start, LIM_C));
          end
          default: ;
        endcase
      end
      KIND_ROTATE: begin
        // The cursor travels with the band only when it sits inside it.
        case (cmd_i.direction)
          DIR_LEFT: begin
            if (in_band(8'(row_q), cmd_i.band_start, w_rows)) col_d = col_dec;
          end
          DIR_RIGHT: begin
            if (in_band(8'(row_q), cmd_i.band_start, w_rows)) col_d = col_inc;
          end
          DIR_UP: begin
            if (in_band(8'(col_q), cmd_i.band_start, w_cols)) row_d = row_dec;
          end
          DIR_DOWN: begin
            if (in_band(8'(col_q), cmd_i.band_start, w_cols)) row_d = row_inc;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (upd_i) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  assign row_o = row_q;
  assign col_o = col_q;

endmodule

// ===== rtl/core/tfb_seq.sv =====
// Command sequencer: walks the frame store RAM for clears, writes, band moves and reads,
// and holds the result register. Depends on tfb_pkg; drives the ports of a tfb_ram.
module tfb_seq #(
  parameter int ROWS    = 2,
  parameter int COLUMNS = 16,
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int CW    = $clog2(COLUMNS),
  localparam int DEPTH = ROWS * COLUMNS,
  localparam int AW    = $clog2(DEPTH),
  localparam int FW    = $clog2(DEPTH + 1),
  localparam int MAXD  = (ROWS > COLUMNS) ? ROWS : COLUMNS,
  localparam int NW    = $clog2(MAXD + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tfb_pkg::cmd_t cmd_i,
  input  logic [RW-1:0] cur_row_i,
  input  logic [CW-1:0] cur_col_i,
  output logic          we_o,
  output logic [AW-1:0] waddr_o,
  output logic [7:0]    wdata_o,
  output logic          re_o,
  output logic [AW-1:0] raddr_o,
  input  logic [7:0]    rdata_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output logic          res_row_o,
  output logic [3:0]    res_col_o,
  output logic [7:0]    res_char_o
);
  import tfb_pkg::*;

  state_e        state_q, state_d;
  cmd_t          cmd_q, cmd_d;
  logic [AW-1:0] fill_addr_q, fill_addr_d, wa_q, wa_d;
  logic [FW-1:0] fill_left_q, fill_left_d;
  logic          stride_q, stride_d, resp_q, resp_d;
  logic [NW-1:0] line_q, line_d, lines_left_q, lines_left_d, j_q, j_d;
  logic [NW-1:0] pend_idx_q, pend_idx_d, len_m1;
  logic          pend_valid_q, pend_valid_d;
  logic [7:0]    keep_q, keep_d;
  logic          out_valid_q, out_valid_d, out_row_q, out_row_d;
  logic [3:0]    out_col_q, out_col_d;
  logic [7:0]    out_char_q, out_char_d;
  logic [7:0]    r8, c8, w8;
  logic          horiz, vert, mv_horiz;

  function automatic logic [AW-1:0] cell_addr(input int unsigned rr, input int unsigned cc);
    return AW'(rr * COLUMNS + cc);
  endfunction

  // Cell j along the current line, in the order the band move reads it.
  function automatic logic [AW-1:0] s_addr(input logic [2:0] dir, input logic [NW-1:0] ln,
                                           input logic [NW-1:0] jj);
    logic [AW-1:0] a;
    case (dir)
      DIR_LEFT:  a = cell_addr(int'(ln), int'(jj));
      DIR_RIGHT: a = cell_addr(int'(ln), COLUMNS - 1 - int'(jj));
      DIR_UP:    a = cell_addr(int'(jj), int'(ln));
      default:   a = cell_addr(ROWS - 1 - int'(jj), int'(ln));
    endcase
    return a;
  endfunction

  always_comb begin
    r8       = clamp_idx(cmd_i.row, 8'(ROWS));
    c8       = clamp_idx(cmd_i.column, 8'(COLUMNS));
    horiz    = (cmd_i.direction == DIR_LEFT) || (cmd_i.direction == DIR_RIGHT);
    vert     = (cmd_i.direction == DIR_UP) || (cmd_i.direction == DIR_DOWN);
    w8       = band_clamp(cmd_i.band_start, cmd_i.band_width,
                          horiz ? 8'(ROWS) : 8'(COLUMNS));
    mv_horiz = (cmd_q.direction == DIR_LEFT) || (cmd_q.direction == DIR_RIGHT);
    len_m1   = mv_horiz ? NW'(COLUMNS - 1) : NW'(ROWS - 1);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (kind_e'(cmd_i.kind))
            KIND_WRITE: state_d = ST_WRITE;
            KIND_CLR_CELL, KIND_CLR_ROW, KIND_CLR_COL, KIND_CLR_ALL: state_d = ST_FILL;
            KIND_SHIFT, KIND_ROTATE: begin
              state_d = ((horiz || vert) && (w8 != 8'd0)) ? ST_MREAD : ST_RDREQ;
            end
            default: state_d = ST_RDREQ;
          endcase
        end
      end
      ST_FILL: begin
        if (fill_left_q == '0) state_d = resp_q ? ST_RDREQ : ST_IDLE;
      end
      ST_WRITE:  state_d = ST_RDREQ;
      ST_MREAD: begin
        if (j_q == len_m1) state_d = ST_MDRAIN;
      end
      ST_MDRAIN: state_d = ST_MLAST;
      ST_MLAST:  state_d = (lines_left_q == NW'(1)) ? ST_RDREQ : ST_MREAD;
      ST_RDREQ:  state_d = ST_RESP;
      ST_RESP: begin
        if (!out_valid_q || res_ready_i) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Memory port, counters and result register.
  always_comb begin
    cmd_d        = cmd_q;
    fill_addr_d  = fill_addr_q;
    fill_left_d  = fill_left_q;
    stride_d     = stride_q;
    resp_d       = resp_q;
    wa_d         = wa_q;
    line_d       = line_q;
    lines_left_d = lines_left_q;
    j_d          = j_q;
    pend_valid_d = 1'b0;
    pend_idx_d   = pend_idx_q;
    keep_d       = keep_q;
    out_valid_d  = out_valid_q;
    out_row_d    = out_row_q;
    out_col_d    = out_col_q;
    out_char_d   = out_char_q;
    we_o         = 1'b0;
    waddr_o      = fill_addr_q;
    wdata_o      = SPACE_CHAR;
    re_o         = 1'b0;
    raddr_o      = wa_q;
    if (out_valid_q && res_ready_i) out_valid_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d        = cmd_i;
          resp_d       = 1'b1;
          stride_d     = 1'b0;
          fill_addr_d  = cell_addr(int'(r8), int'(c8));
          fill_left_d  = '0;
          wa_d         = (kind_e'(cmd_i.kind) == KIND_WRITE) ?
                         cell_addr(int'(cur_row_i), int'(cur_col_i)) :
                         cell_addr(int'(r8), int'(c8));
          line_d       = NW'(cmd_i.band_start);
          lines_left_d = NW'(w8);
          j_d          = '0;
          case (kind_e'(cmd_i.kind))
            KIND_CLR_CELL: fill_left_d = FW'(1);
            KIND_CLR_ROW: begin
              fill_addr_d = cell_addr(int'(r8), int'(cmd_i.column));
              if (int'(cmd_i.column) < COLUMNS) begin
                fill_left_d = FW'(COLUMNS - int'(cmd_i.column));
              end
            end
            KIND_CLR_COL: begin
              fill_addr_d = cell_addr(int'(cmd_i.row), int'(c8));
              stride_d    = 1'b1;
              if (int'(cmd_i.row) < ROWS) begin
                fill_left_d = FW'(ROWS - int'(cmd_i.row));
              end
            end
            KIND_CLR_ALL: begin
              fill_addr_d = '0;
              fill_left_d = FW'(DEPTH);
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        if (fill_left_q != '0) begin
          we_o        = 1'b1;
          waddr_o     = fill_addr_q;
          fill_addr_d = fill_addr_q + (stride_q ? AW'(COLUMNS) : AW'(1));
          fill_left_d = fill_left_q - FW'(1);
        end
      end
      ST_WRITE: begin
        we_o    = 1'b1;
        waddr_o = wa_q;
        wdata_o = cmd_q.char_code;
      end
      ST_MREAD: begin
        re_o         = 1'b1;
        raddr_o      = s_addr(cmd_q.direction, line_q, j_q);
        pend_valid_d = 1'b1;
        pend_idx_d   = j_q;
        j_d          = j_q + NW'(1);
      end
      ST_MLAST: begin
        we_o         = 1'b1;
        waddr_o      = s_addr(cmd_q.direction, line_q, len_m1);
        wdata_o      = (kind_e'(cmd_q.kind) == KIND_ROTATE) ? keep_q : SPACE_CHAR;
        lines_left_d = lines_left_q - NW'(1);
        line_d       = line_q + NW'(1);
        j_d          = '0;
      end
      ST_RDREQ: begin
        re_o    = 1'b1;
        raddr_o = (kind_e'(cmd_q.kind) == KIND_READ) ? wa_q :
                  cell_addr(int'(cur_row_i), int'(cur_col_i));
      end
      ST_RESP: begin
        if (!out_valid_q || res_ready_i) begin
          out_valid_d = 1'b1;
          out_row_d   = 1'(cur_row_i);
          out_col_d   = 4'(cur_col_i);
          out_char_d  = rdata_i;
        end
      end
      default: ;
    endcase

    // The word read in the previous cycle moves one place back along the line;
    // the first one is kept for the wrap-around end.
    if (pend_valid_q) begin
      if (pend_idx_q == '0) begin
        keep_d = rdata_i;
      end else begin
        we_o    = 1'b1;
        waddr_o = s_addr(cmd_q.direction, line_q, pend_idx_q - NW'(1));
        wdata_o = rdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_FILL;
      fill_addr_q  <= '0;
      fill_left_q  <= FW'(DEPTH);
      stride_q     <= 1'b0;
      resp_q       <= 1'b0;
      line_q       <= '0;
      lines_left_q <= '0;
      j_q          <= '0;
      pend_valid_q <= 1'b0;
      pend_idx_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      fill_addr_q  <= fill_addr_d;
      fill_left_q  <= fill_left_d;
      stride_q     <= stride_d;
      resp_q       <= resp_d;
      line_q       <= line_d;
      lines_left_q <= lines_left_d;
      j_q          <= j_d;
      pend_valid_q <= pend_valid_d;
      pend_idx_q   <= pend_idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    wa_q       <= wa_d;
    keep_q     <= keep_d;
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
    out_char_q <= out_char_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = out_valid_q;
  assign res_row_o   = out_row_q;
  assign res_col_o   = out_col_q;
  assign res_char_o  = out_char_q;

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we_o && re_o && (waddr_o == raddr_o)))
    else $error("frame store read and written at the same cell in one cycle");

  a_pend_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> $past(state_q == ST_MREAD))
    else $error("move data pending without a read issued");

  a_lines_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MREAD || state_q == ST_MLAST) |-> (lines_left_q != '0))
    else $error("band move running with no lines left");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL && fill_left_q != '0) |-> (int'(fill_addr_q) < DEPTH))
    else $error("clear sweep outside the frame store");

endmodule

// ===== rtl/core/text_frame_buffer_cursor_engine.sv =====
// All words share the single RAM port pair: a write stores its char at the cursor cell,
// clears sweep the cleared cells, shift/rotate walk each band line, and every word ends
// with the result read. Throughput: one word at a time; the worst case is a full vertical
// band move at 2x16. The result register lets the next word enter while a result waits.
// Reset: the cursor goes to (0, 0) and a clearing pass writes spaces to all
// ROWS*COLUMNS cells, one per cycle, with s_axis_tready low.
module text_frame_buffer_cursor_engine #(
  parameter int ROWS    = 2,
  parameter int COLUMNS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // kind[3:0], char_code[11:4], row[19:12], column[27:20], direction[30:28],
  // band_start[38:31], band_width[46:39], zero pad [47]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // cursor_row[0], cursor_column[4:1], cell_char[12:5], zero pad [15:13]
  output logic [15:0] m_axis_tdata
);
  import tfb_pkg::*;

  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = $clog2(COLUMNS);
  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = $clog2(DEPTH);

  cmd_t          cmd;
  logic          accept;
  logic [RW-1:0] cur_row;
  logic [CW-1:0] cur_col;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;
  logic          res_row;
  logic [3:0]    res_col;
  logic [7:0]    res_char;

  assign cmd    = cmd_t'(s_axis_tdata[46:0]);
  assign accept = s_axis_tvalid && s_axis_tready;

  tfb_cursor #(.ROWS(ROWS), .COLUMNS(COLUMNS)) u_cursor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (accept),
    .cmd_i  (cmd),
    .row_o  (cur_row),
    .col_o  (cur_col)
  );

  tfb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  tfb_seq #(.ROWS(ROWS), .COLUMNS(COLUMNS)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cmd_i       (cmd),
    .cur_row_i   (cur_row),
    .cur_col_i   (cur_col),
    .we_o        (mem_we),
    .waddr_o     (mem_waddr),
    .wdata_o     (mem_wdata),
    .re_o        (mem_re),
    .raddr_o     (mem_raddr),
    .rdata_i     (mem_rdata),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_row_o   (res_row),
    .res_col_o   (res_col),
    .res_char_o  (res_char)
  );

  assign m_axis_tdata = {3'b000, res_char, res_col, res_row};

endmodule
